// ===== hdl/audio_peak_level_meter_macros.svh =====
// Assertion macros for the audio peak level meter.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef AUDIO_PEAK_LEVEL_METER_MACROS_SVH
`define AUDIO_PEAK_LEVEL_METER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define APM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define APM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/apm_pkg.sv =====
// Package for the audio peak level meter: widths, reset values, register
// indexes, LED duty codes and the result word type. No dependencies.
`timescale 1ns / 1ps

package apm_pkg;

  localparam int SampleW = 16;
  localparam int PeakW   = 15;
  localparam int ScaleW  = 13;
  localparam int StepW   = 10;
  localparam int LevelW  = 3;
  localparam int DutyW   = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam logic [ScaleW-1:0]  ScaleMax       = 13'd8191;
  localparam logic [ScaleW-1:0]  BaseScaleRst   = 13'd100;
  localparam logic [StepW-1:0]   ScaleStepRst   = 10'd100;
  localparam logic [ScaleW-1:0]  StartScaleRst  = 13'd700;
  localparam logic [SampleW-1:0] IgnoreValueRst = 16'd18161;

  localparam logic [LevelW-1:0] LevelTop = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_SCALE   = 2'd0,
    CFG_SCALE_STEP   = 2'd1,
    CFG_START_SCALE  = 2'd2,
    CFG_IGNORE_VALUE = 2'd3
  } cfg_idx_t;

  typedef enum logic [DutyW-1:0] {
    DUTY_OFF  = 2'd0,
    DUTY_HALF = 2'd1,
    DUTY_FULL = 2'd2
  } duty_t;

  typedef struct packed {
    duty_t red;
    duty_t green;
    duty_t blue;
  } led_t;

  typedef struct packed {
    logic [PeakW-1:0]  peak;
    logic [LevelW-1:0] level;
    led_t              led;
    logic              all_off;
    logic [ScaleW-1:0] scale_used;
  } result_t;

  // LED color pattern for each level band.
  function automatic led_t led_for_level(input logic [LevelW-1:0] lvl);
    led_t l;
    case (lvl)
      3'd1:    l = '{red: DUTY_FULL, green: DUTY_OFF,  blue: DUTY_OFF};
      3'd2:    l = '{red: DUTY_FULL, green: DUTY_HALF, blue: DUTY_OFF};
      3'd3:    l = '{red: DUTY_OFF,  green: DUTY_HALF, blue: DUTY_OFF};
      3'd4:    l = '{red: DUTY_OFF,  green: DUTY_HALF, blue: DUTY_HALF};
      3'd5:    l = '{red: DUTY_OFF,  green: DUTY_OFF,  blue: DUTY_HALF};
      3'd6:    l = '{red: DUTY_FULL, green: DUTY_OFF,  blue: DUTY_HALF};
      3'd7:    l = '{red: DUTY_FULL, green: DUTY_HALF, blue: DUTY_HALF};
      default: l = '{red: DUTY_OFF,  green: DUTY_OFF,  blue: DUTY_OFF};
    endcase
    return l;
  endfunction

endpackage

// ===== hdl/audio_peak_level_meter.sv =====
// Top level of the audio peak level meter: peak tracking, level classification,
// auto-ranging scale and a two-word output buffer. Depends on apm_pkg and the macros header.
`timescale 1ns / 1ps
`include "audio_peak_level_meter_macros.svh"

// Usage notes.
// The input channel carries one word per audio sample: in_sample (signed 16 bit) and
// in_window_end, which marks the last sample of a peak window. A word is taken at a
// rising edge where in_valid is high and in_stall is low.
// Every accepted sample is folded into the running peak in the same cycle. A word with
// in_window_end set also produces one result word, registered at that edge in the main
// register (skid register if the main word is held). Words without window end give no result.
// Throughput is one sample per cycle unless in_stall is high; classification is combinational.
// The result side holds a main output register and one skid register. While a result
// waits under out_stall, the block keeps taking samples; in_stall rises only once the
// skid register is also occupied, and drops as soon as the receiver drains a word.
// The cfg_ port writes one register per cycle with cfg_we; writes are expected only
// while the block is idle. A start_scale write loads the live scale at once.
// Reset (rst_n low at a clock edge) clears the running peak, loads the scale with 700,
// restores the configuration registers to their defaults and empties the output buffer.
module audio_peak_level_meter (
  input  logic                          clk,
  input  logic                          rst_n,
  // Sample input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [apm_pkg::SampleW-1:0] in_sample,
  input  logic                          in_window_end,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [apm_pkg::PeakW-1:0]     out_peak,
  output logic [apm_pkg::LevelW-1:0]    out_level,
  output logic [apm_pkg::DutyW-1:0]     out_red_duty,
  output logic [apm_pkg::DutyW-1:0]     out_green_duty,
  output logic [apm_pkg::DutyW-1:0]     out_blue_duty,
  output logic                          out_all_off,
  output logic [apm_pkg::ScaleW-1:0]    out_scale_used,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [apm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [apm_pkg::CfgDataW-1:0]  cfg_wdata
);

  import apm_pkg::*;

  // Configuration registers. start_scale has no register of its own: it only
  // matters as the value loaded into the live scale.
  logic [ScaleW-1:0]  base_scale_r;
  logic [StepW-1:0]   scale_step_r;
  logic [SampleW-1:0] ignore_value_r;

  // Block state. The running peak never goes negative, so 15 bits hold it.
  logic [PeakW-1:0]  running_peak_r, running_peak_nxt;
  logic [ScaleW-1:0] current_scale_r, current_scale_nxt;

  // Output buffer: main register drives the ports, skid register catches one more word.
  result_t main_r, skid_r;
  logic    main_valid_r, skid_valid_r;

  logic    in_acc;
  logic    produce;
  logic    out_fire;
  result_t res;

  logic [PeakW-1:0]  peak_fold;
  logic [LevelW-1:0] level;
  logic [ScaleW:0]   scale_up;
  logic [ScaleW:0]   scale_floor;
  logic              go_up, go_down;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign produce  = in_acc && in_window_end;
  assign out_fire = main_valid_r && !out_stall;

  // Fold the sample into the peak. A negative sample never wins against a peak of
  // zero or more, and the ignore value is never taken.
  always_comb begin
    peak_fold = running_peak_r;
    if (!in_sample[SampleW-1] && (in_sample[PeakW-1:0] > running_peak_r) &&
        (in_sample != ignore_value_r)) begin
      peak_fold = in_sample[PeakW-1:0];
    end
  end

  // Level band: the highest k in 1..7 with k * scale <= peak. The multiples are
  // constant multiplies (shift and add), compared in parallel.
  always_comb begin
    level = '0;
    for (int k = 1; k <= 7; k++) begin
      if ({1'b0, peak_fold} >= (16'(k) * {3'b000, current_scale_r})) begin
        level = 3'(k);
      end
    end
  end

  // Auto-ranging. A zero scale counts as "peak at or above eight scales".
  assign go_up       = {1'b0, peak_fold} >= {current_scale_r, 3'b000};
  assign go_down     = ({1'b0, peak_fold} < {3'b000, current_scale_r}) &&
                       ({1'b0, current_scale_r} >= scale_floor);
  assign scale_up    = {1'b0, current_scale_r} + {{(ScaleW + 1 - StepW){1'b0}}, scale_step_r};
  assign scale_floor = {{(ScaleW + 1 - StepW){1'b0}}, scale_step_r} + {1'b0, base_scale_r};

  always_comb begin
    current_scale_nxt = current_scale_r;
    running_peak_nxt  = running_peak_r;
    if (in_acc) begin
      running_peak_nxt = in_window_end ? '0 : peak_fold;
      if (in_window_end) begin
        if (go_up) begin
          current_scale_nxt = (scale_up > {1'b0, ScaleMax}) ? ScaleMax
                                                            : scale_up[ScaleW-1:0];
        end else if (go_down) begin
          current_scale_nxt = current_scale_r - {{(ScaleW - StepW){1'b0}}, scale_step_r};
        end
      end
    end
    // A start_scale write takes effect at once.
    if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_START_SCALE)) begin
      current_scale_nxt = cfg_wdata[ScaleW-1:0];
    end
  end

  always_comb begin
    res.peak       = peak_fold;
    res.level      = level;
    res.led        = led_for_level(level);
    res.all_off    = (level == '0);
    res.scale_used = current_scale_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_scale_r   <= BaseScaleRst;
      scale_step_r   <= ScaleStepRst;
      ignore_value_r <= IgnoreValueRst;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE_SCALE:   base_scale_r   <= cfg_wdata[ScaleW-1:0];
        CFG_SCALE_STEP:   scale_step_r   <= cfg_wdata[StepW-1:0];
        CFG_IGNORE_VALUE: ignore_value_r <= cfg_wdata[SampleW-1:0];
        default: ;
      endcase
    end
  end

  // Peak and scale state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_peak_r  <= '0;
      current_scale_r <= StartScaleRst;
    end else begin
      running_peak_r  <= running_peak_nxt;
      current_scale_r <= current_scale_nxt;
    end
  end

  // Output buffer control. When the main register is free (empty or draining) it
  // takes the skid word first, else a fresh result. When it is held, a fresh result
  // parks in the skid register; in_stall then blocks further input.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_fire) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= produce;
      end
    end else if (produce) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_fire) begin
      main_r <= skid_valid_r ? skid_r : res;
    end
    if (main_valid_r && !out_fire && produce) begin
      skid_r <= res;
    end
  end

  assign out_valid      = main_valid_r;
  assign out_peak       = main_r.peak;
  assign out_level      = main_r.level;
  assign out_red_duty   = main_r.led.red;
  assign out_green_duty = main_r.led.green;
  assign out_blue_duty  = main_r.led.blue;
  assign out_all_off    = main_r.all_off;
  assign out_scale_used = main_r.scale_used;

  // The skid register is only ever filled behind a held main word.
  `APM_ASSERT_NOW(a_skid_behind_main, skid_valid_r, main_valid_r, "skid full with main empty")
  // The all-off flag tracks the zero level band.
  `APM_ASSERT_NOW(a_all_off_level, main_valid_r, main_r.all_off == (main_r.level == '0),
                  "all_off disagrees with level")
  // Inside a window the running peak can only grow.
  `APM_ASSERT_NEXT(a_peak_monotonic, in_acc && !in_window_end,
                   running_peak_r >= $past(running_peak_r), "running peak fell inside window")

endmodule
